// ===== rtl/sln_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sln_pkg: shared types and constants of the source line normalizer
// Character codes, line limit, queue sizing, config indexes, beat bundles.
// ----------------------------------------------------------------------------
package sln_pkg;

  localparam int MAX_LINE = 128;
  localparam int LEN_W    = $clog2(MAX_LINE);
  localparam int LINE_W   = 16;

  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int Q_CW     = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_BLANK = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7a;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [7:0] COMMENT_RESET = 8'd59;
  localparam logic [7:0] QUOTE_RESET   = 8'd34;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMENT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE   = 8'd1;

  typedef struct packed {
    logic [7:0] comment_char;
    logic [7:0] quote_char;
  } cfg_t;

  // Up to three output beats caused by one input byte, in order:
  // a released blank, a kept character, an end marker.
  typedef struct packed {
    logic              has_blank;
    logic              has_char;
    logic              has_eol;
    logic [7:0]        chr;
    logic              too_long;
    logic [LINE_W-1:0] line_number;
  } bundle_t;

endpackage

// ===== rtl/sln_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sln_front: byte classifier
// One byte per cycle unless q_full; tracks line state, pushes beat bundles.
// ----------------------------------------------------------------------------
module sln_front (
  input  logic                clk,
  input  logic                rst,
  input  sln_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_byte,
  input  logic                q_full,
  output logic                q_push,
  output sln_pkg::bundle_t    q_data
);

  logic                            in_quote, in_quote_next;
  logic                            in_comment, in_comment_next;
  logic                            pending_blank, pending_blank_next;
  logic                            line_has_output, line_has_output_next;
  logic [7:0]                      prev_kept_char, prev_kept_char_next;
  logic [sln_pkg::LEN_W-1:0]       raw_length, raw_length_next;
  logic [sln_pkg::LINE_W-1:0]      line_counter, line_counter_next;

  logic                            accept;
  logic [7:0]                      c;
  logic [7:0]                      prev;
  logic                            quote_after;
  logic [sln_pkg::LEN_W-1:0]       len_inc;
  sln_pkg::bundle_t                bnd;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    in_quote_next        = in_quote;
    in_comment_next      = in_comment;
    pending_blank_next   = pending_blank;
    line_has_output_next = line_has_output;
    prev_kept_char_next  = prev_kept_char;
    raw_length_next      = raw_length;
    line_counter_next    = line_counter;
    bnd                  = '0;
    bnd.line_number      = line_counter + sln_pkg::LINE_W'(1);
    len_inc              = raw_length + sln_pkg::LEN_W'(1);
    quote_after          = in_quote;
    prev                 = pending_blank ? sln_pkg::CH_BLANK : prev_kept_char;
    c                    = in_byte;
    if (in_byte >= sln_pkg::CH_LC_A && in_byte <= sln_pkg::CH_LC_Z) begin
      c = in_byte - sln_pkg::CASE_OFS;
    end

    if (in_byte == sln_pkg::CH_LF || in_byte == sln_pkg::CH_CR) begin
      bnd.has_eol          = line_has_output;
      line_counter_next    = line_counter + sln_pkg::LINE_W'(1);
      in_quote_next        = 1'b0;
      in_comment_next      = 1'b0;
      pending_blank_next   = 1'b0;
      line_has_output_next = 1'b0;
      raw_length_next      = '0;
    end else begin
      raw_length_next = len_inc;
      if (!in_comment) begin
        if (c == sln_pkg::CH_NUL || (c == cfg.comment_char && !in_quote)) begin
          in_comment_next = 1'b1;
        end else begin
          quote_after   = in_quote ^ (c == cfg.quote_char);
          in_quote_next = quote_after;
          if (c == sln_pkg::CH_BLANK) begin
            if (line_has_output && (quote_after ||
                (prev != sln_pkg::CH_BLANK && prev != sln_pkg::CH_COMMA))) begin
              bnd.has_blank      = pending_blank;
              pending_blank_next = 1'b1;
              if (pending_blank) begin
                prev_kept_char_next = sln_pkg::CH_BLANK;
              end
            end
          end else if (c == sln_pkg::CH_TAB) begin
            if (line_has_output && prev != sln_pkg::CH_BLANK &&
                prev != sln_pkg::CH_COMMA) begin
              pending_blank_next = 1'b1;
            end
          end else begin
            bnd.has_blank        = pending_blank;
            bnd.has_char         = 1'b1;
            bnd.chr              = c;
            pending_blank_next   = 1'b0;
            prev_kept_char_next  = c;
            line_has_output_next = 1'b1;
          end
        end
      end
      if (32'(len_inc) >= sln_pkg::MAX_LINE - 1) begin
        bnd.has_eol          = line_has_output_next;
        bnd.too_long         = 1'b1;
        line_counter_next    = line_counter + sln_pkg::LINE_W'(1);
        in_quote_next        = 1'b0;
        in_comment_next      = 1'b0;
        pending_blank_next   = 1'b0;
        line_has_output_next = 1'b0;
        raw_length_next      = '0;
      end
    end
  end

  assign q_push = accept && (bnd.has_blank || bnd.has_char || bnd.has_eol);
  assign q_data = bnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quote        <= 1'b0;
      in_comment      <= 1'b0;
      pending_blank   <= 1'b0;
      line_has_output <= 1'b0;
      prev_kept_char  <= '0;
      raw_length      <= '0;
      line_counter    <= '0;
    end else if (accept) begin
      in_quote        <= in_quote_next;
      in_comment      <= in_comment_next;
      pending_blank   <= pending_blank_next;
      line_has_output <= line_has_output_next;
      prev_kept_char  <= prev_kept_char_next;
      raw_length      <= raw_length_next;
      line_counter    <= line_counter_next;
    end
  end

endmodule

// ===== rtl/sln_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sln_queue: bundle queue
// Short register FIFO between the classifier and the beat sequencer.
// ----------------------------------------------------------------------------
module sln_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sln_pkg::bundle_t push_data,
  input  logic             pop,
  output sln_pkg::bundle_t pop_data,
  output logic             full,
  output logic             empty
);

  sln_pkg::bundle_t             mem [sln_pkg::Q_DEPTH];
  logic [sln_pkg::Q_AW-1:0]     wr_ptr;
  logic [sln_pkg::Q_AW-1:0]     rd_ptr;
  logic [sln_pkg::Q_CW-1:0]     count;
  logic                         do_push;
  logic                         do_pop;

  assign full     = (32'(count) == sln_pkg::Q_DEPTH);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + sln_pkg::Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + sln_pkg::Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + sln_pkg::Q_CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - sln_pkg::Q_CW'(1);
      end
    end
  end

endmodule

// ===== rtl/sln_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sln_back: beat sequencer
// Holds one bundle in its output register and sends its beats in order.
// ----------------------------------------------------------------------------
module sln_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  sln_pkg::bundle_t           q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_char,
  output logic                       end_of_line,
  output logic [sln_pkg::LINE_W-1:0] line_number,
  output logic                       line_too_long,
  output logic                       run_last
);

  sln_pkg::bundle_t cur;
  logic             busy;
  logic [2:0]       rem, rem_next;
  logic [2:0]       first;
  logic             beat_taken;
  logic             load;

  always_comb begin
    first = 3'b000;
    if (rem[0]) begin
      first = 3'b001;
    end else if (rem[1]) begin
      first = 3'b010;
    end else if (rem[2]) begin
      first = 3'b100;
    end
  end

  assign rem_next   = rem & ~first;
  assign out_valid  = busy;
  assign beat_taken = busy && !out_stall;
  assign run_last   = (rem_next == 3'b000);
  assign load       = !q_empty && (!busy || (beat_taken && run_last));
  assign q_pop      = load;

  assign out_char      = first[0] ? sln_pkg::CH_BLANK : (first[1] ? cur.chr : 8'h00);
  assign end_of_line   = first[2];
  assign line_too_long = first[2] && cur.too_long;
  assign line_number   = cur.line_number;

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rem  <= 3'b000;
    end else if (load) begin
      busy <= 1'b1;
      rem  <= {q_data.has_eol, q_data.has_char, q_data.has_blank};
    end else if (beat_taken) begin
      busy <= !run_last;
      rem  <= rem_next;
    end
  end

endmodule

// ===== rtl/source_line_normalizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_line_normalizer: raw source bytes to normalized line beats
// Classifier front, bundle queue, beat sequencer with registered output.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | sink      | in_valid / in_stall  | in_byte
//   out     | source    | out_valid / out_stall| out_char, end_of_line,
//           |           |                      | line_number, line_too_long,
//           |           |                      | run_last
//   cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One input byte is accepted per cycle while the bundle queue has room.
// Each byte yields zero to three output beats; the sequencer sends one beat
// per cycle unless out_stall, so output beats set the sustained rate when
// bytes expand. A byte's first output beat passes the bundle queue and then
// the sequencer's output register before it is valid.
// Synchronous reset clears line state, the queue and the sequencer's valid.
// Output stall backs up the queue; the input stalls only when it is full.
// ----------------------------------------------------------------------------
module source_line_normalizer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_char,
  output logic                            end_of_line,
  output logic [sln_pkg::LINE_W-1:0]      line_number,
  output logic                            line_too_long,
  output logic                            run_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sln_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                      cfg_data
);

  sln_pkg::cfg_t    cfg;
  sln_pkg::bundle_t push_data;
  sln_pkg::bundle_t pop_data;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.comment_char <= sln_pkg::COMMENT_RESET;
      cfg.quote_char   <= sln_pkg::QUOTE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sln_pkg::CFG_COMMENT: cfg.comment_char <= cfg_data;
        sln_pkg::CFG_QUOTE:   cfg.quote_char   <= cfg_data;
        default: ;
      endcase
    end
  end

  sln_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  sln_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  sln_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (pop_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .end_of_line   (end_of_line),
    .line_number   (line_number),
    .line_too_long (line_too_long),
    .run_last      (run_last)
  );

  a_rst_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_eol_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_line |-> run_last && out_char == 8'h00)
    else $error("end marker not last beat of its byte");

  a_too_long_on_eol: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_too_long |-> end_of_line)
    else $error("too-long flag on character beat");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_last |=> out_valid)
    else $error("beat run broken before its last beat");

endmodule
